/* src/mhtcw_pkg.sv */
// shared types, codes and register map for the window-cycle controller
`default_nettype none
package mhtcw_pkg;

  // event kinds carried by a request
  localparam logic [2:0] KIND_BIND_PRESS   = 3'd0;
  localparam logic [2:0] KIND_BIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_KEY_EVENT    = 3'd2;
  localparam logic [2:0] KIND_LAYER_EVENT  = 3'd3;
  localparam logic [2:0] KIND_TICK         = 3'd4;

  // register indexes, taken from paddr[3:2]
  localparam int          ADDR_W           = 4;
  localparam logic [1:0]  REG_WINDOW_LEN   = 2'd0;
  localparam logic [1:0]  REG_IGNORED_CNT  = 2'd1;
  localparam logic [1:0]  REG_IGNORED_A    = 2'd2;
  localparam logic [1:0]  REG_IGNORED_B    = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
  localparam logic [1:0]  IGNORED_CNT_RESET = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] key_position;
    logic [4:0] layer_id;
    logic       is_on;
    logic       alt_held;
  } in_item_t;

  typedef struct packed {
    logic       alt_press;
    logic       alt_release;
    logic       tab_press;
    logic       tab_release;
    logic [7:0] action_position;
    logic [4:0] action_layer;
    logic       window_open;
  } out_item_t;

  typedef struct packed {
    logic [15:0] window_len;
    logic [1:0]  ignored_count;
    logic [7:0]  ignored_position_a;
    logic [7:0]  ignored_position_b;
  } cfg_t;

endpackage
`default_nettype wire

/* src/mhtcw_ifs.sv */
// valid/ready channel interfaces for event requests and results
`default_nettype none
interface mhtcw_in_if import mhtcw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mhtcw_out_if import mhtcw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/mhtcw_cfg.sv */
// apb-style configuration register file
`default_nettype none
module mhtcw_cfg import mhtcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_len         <= TIMEOUT_RESET;
      cfg.ignored_count      <= IGNORED_CNT_RESET;
      cfg.ignored_position_a <= 8'd0;
      cfg.ignored_position_b <= 8'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW_LEN:  cfg.window_len         <= pwdata[15:0];
        REG_IGNORED_CNT: cfg.ignored_count      <= pwdata[1:0];
        REG_IGNORED_A:   cfg.ignored_position_a <= pwdata[7:0];
        REG_IGNORED_B:   cfg.ignored_position_b <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_LEN:  prdata = {16'd0, cfg.window_len};
      REG_IGNORED_CNT: prdata = {30'd0, cfg.ignored_count};
      REG_IGNORED_A:   prdata = {24'd0, cfg.ignored_position_a};
      REG_IGNORED_B:   prdata = {24'd0, cfg.ignored_position_b};
      default:         prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

/* src/mhtcw_core.sv */
// request register, window state update and result register
`default_nettype none
module mhtcw_core import mhtcw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  mhtcw_in_if.sink   in_ch,
  mhtcw_out_if.source out_ch
);

  // request stage
  logic      s1_valid;
  in_item_t  s1_item;
  // result stage
  logic      out_valid;
  out_item_t out_item;
  // window state
  logic        window_active, window_active_next;
  logic        alt_owned, alt_owned_next;
  logic        tab_held, tab_held_next;
  logic [7:0]  anchor_position, anchor_position_next;
  logic [4:0]  anchor_layer, anchor_layer_next;
  logic [15:0] remaining_ms, remaining_ms_next;

  logic      advance;
  logic      fire;
  logic      ignored;
  out_item_t res;

  assign advance     = !out_valid || out_ch.ready;
  assign fire        = s1_valid && advance;
  assign in_ch.ready = !s1_valid || advance;

  // anchor key always ignored; a count of three behaves as two
  assign ignored = (s1_item.key_position == anchor_position)
                || ((cfg.ignored_count != 2'd0)
                    && (s1_item.key_position == cfg.ignored_position_a))
                || (cfg.ignored_count[1]
                    && (s1_item.key_position == cfg.ignored_position_b));

  always_comb begin
    window_active_next   = window_active;
    alt_owned_next       = alt_owned;
    tab_held_next        = tab_held;
    anchor_position_next = anchor_position;
    anchor_layer_next    = anchor_layer;
    remaining_ms_next    = remaining_ms;
    res                  = '0;

    case (s1_item.kind)
      KIND_BIND_PRESS: begin
        if (!window_active) begin
          window_active_next   = 1'b1;
          anchor_position_next = s1_item.key_position;
          anchor_layer_next    = s1_item.layer_id;
          alt_owned_next       = !s1_item.alt_held;
          res.alt_press        = !s1_item.alt_held;
        end
        // opening a window forgets a held tab
        if (!tab_held || !window_active) begin
          res.tab_press = 1'b1;
        end
        tab_held_next = 1'b1;
        if (cfg.window_len != 16'd0) begin
          remaining_ms_next = cfg.window_len;
        end
      end
      KIND_BIND_RELEASE: begin
        res.tab_release = tab_held;
        tab_held_next   = 1'b0;
      end
      KIND_KEY_EVENT: begin
        if (s1_item.is_on && window_active && !ignored) begin
          res.alt_release    = alt_owned;
          window_active_next = 1'b0;
          alt_owned_next     = 1'b0;
          remaining_ms_next  = 16'd0;
        end
      end
      KIND_LAYER_EVENT: begin
        if (!s1_item.is_on && window_active && (s1_item.layer_id == anchor_layer)) begin
          res.alt_release    = alt_owned;
          window_active_next = 1'b0;
          alt_owned_next     = 1'b0;
          remaining_ms_next  = 16'd0;
        end
      end
      KIND_TICK: begin
        if (remaining_ms != 16'd0) begin
          remaining_ms_next = remaining_ms - 16'd1;
          if ((remaining_ms == 16'd1) && window_active) begin
            res.alt_release    = alt_owned;
            window_active_next = 1'b0;
            alt_owned_next     = 1'b0;
          end
        end
      end
      default: ;
    endcase

    res.action_position = anchor_position_next;
    res.action_layer    = anchor_layer_next;
    res.window_open     = window_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      window_active   <= 1'b0;
      alt_owned       <= 1'b0;
      tab_held        <= 1'b0;
      anchor_position <= 8'd0;
      anchor_layer    <= 5'd0;
      remaining_ms    <= 16'd0;
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (fire) begin
        window_active   <= window_active_next;
        alt_owned       <= alt_owned_next;
        tab_held        <= tab_held_next;
        anchor_position <= anchor_position_next;
        anchor_layer    <= anchor_layer_next;
        remaining_ms    <= remaining_ms_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item <= in_ch.data;
    end
    if (fire) begin
      out_item <= res;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  a_owned_needs_window: assert property (@(posedge clk) disable iff (rst)
    alt_owned |-> window_active)
    else $error("alt owned with no open window");

  a_idle_no_countdown: assert property (@(posedge clk) disable iff (rst)
    !window_active |-> (remaining_ms == 16'd0))
    else $error("countdown pending with window closed");

  a_alt_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.alt_press && out_item.alt_release))
    else $error("alt pressed and released in one result");

  a_tab_press_holds: assert property (@(posedge clk) disable iff (rst)
    (fire && res.tab_press) |=> tab_held)
    else $error("tab pressed but not marked held");

endmodule
`default_nettype wire

/* src/modifier_hold_tab_cycle_window_top.sv */
// top level of the alt-tab window-cycle controller
`default_nettype none
// Alt-tab style window-cycle controller. Each request is one keyboard event:
// binding press or release, physical key event, layer event or a 1 ms tick.
// Every request accepted yields exactly one result carrying the alt/tab
// press and release actions it caused, the stored window position and layer,
// and whether the window is open afterwards. Throughput is one request per
// clock while the result channel is not stalled; a request is taken into the
// request register, and its result, formed by the single pass of flag and
// compare logic between the two registers, is held valid in the result
// register. A waiting result does not block the next request unless the
// request register is also full. Registers (APB, byte address 4*i): window
// length in ms ticks (0 = never expires), ignored_count, ignored_position_a,
// ignored_position_b; write them only while no request is in flight.
module modifier_hold_tab_cycle_window_top import mhtcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration port, pready is tied high
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  // event requests in, results out
  mhtcw_in_if.sink               in_ch,
  mhtcw_out_if.source            out_ch
);

  // live register values towards the datapath
  cfg_t cfg;

  mhtcw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // request register, window state and result register
  mhtcw_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
